// ===== src/inverter_deadtime_compensation_top_assert.svh =====
// Assertion macros for the dead-time compensation block.
// Included by the top level; no other dependencies.
`ifndef INVERTER_DEADTIME_COMPENSATION_TOP_ASSERT_SVH
`define INVERTER_DEADTIME_COMPENSATION_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define DTC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define DTC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DTC_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define DTC_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// ===== src/dtc_pkg.sv =====
// Shared types and constants for the dead-time compensation block.
// No dependencies.
`timescale 1ns / 1ps

package dtc_pkg;

  // pipeline depth, input register through output register
  localparam int NUM_STAGES = 8;

  localparam logic [14:0] SQRT3_HALF_Q15 = 15'd28378;
  // 2 * sqrt(3)/2 in Q1.15
  localparam logic [15:0] BETA_GAIN      = 16'd56756;
  // ceil(2^21 / 3): exact floor(y/3) for y < 2^21
  localparam logic [19:0] DIV3_RECIP     = 20'd699051;
  localparam int          DIV3_SHIFT     = 21;

  typedef enum logic [1:0] {
    REG_DEAD_RATIO    = 2'd0,
    REG_DIODE_DROP    = 2'd1,
    REG_ON_RESISTANCE = 2'd2,
    REG_DEADBAND      = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [15:0] dead_ratio;
    logic [14:0] diode_drop;
    logic [15:0] on_resistance;
    logic [14:0] current_deadband;
  } dtc_cfg_t;

endpackage

// ===== src/dtc_datapath.sv =====
// Eight-stage compensation datapath: inverse Clarke, per-phase
// compensation, Clarke, divide by three, add and saturate. Uses dtc_pkg.
`timescale 1ns / 1ps

module dtc_datapath import dtc_pkg::*; (
  input  logic                  clk,
  input  logic [NUM_STAGES-1:0] en,
  input  dtc_cfg_t              cfg,
  input  logic signed [15:0]    v_cmd_alpha,
  input  logic signed [15:0]    v_cmd_beta,
  input  logic signed [15:0]    i_alpha,
  input  logic signed [15:0]    i_beta,
  input  logic [14:0]           vdc,
  output logic signed [15:0]    v_out_alpha,
  output logic signed [15:0]    v_out_beta,
  output logic                  clipped
);

  typedef enum logic [1:0] {
    SGN_ZERO = 2'd0,
    SGN_POS  = 2'd1,
    SGN_NEG  = 2'd2
  } sgn_t;

  // round(num / 2^15), ties away from zero
  function automatic logic signed [16:0] rnd15(input logic signed [31:0] num);
    logic [31:0] mag;
    logic [16:0] q;
    mag = num[31] ? 32'(-num) : 32'(num);
    q   = 17'((33'(mag) + 33'd16384) >> 15);
    return num[31] ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic [15:0] abs17(input logic signed [16:0] v);
    logic signed [16:0] m;
    m = v[16] ? -v : v;
    return m[15:0];
  endfunction

  function automatic logic signed [18:0] sat_in(input logic signed [19:0] v,
                                                 input logic neg);
    return 19'(neg ? -v : v);
  endfunction

  // command pass-through line, stages 0..6
  logic signed [15:0] vca_q [NUM_STAGES-1];
  logic signed [15:0] vcb_q [NUM_STAGES-1];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      vca_q[0] <= v_cmd_alpha;
      vcb_q[0] <= v_cmd_beta;
    end
    for (int k = 1; k < NUM_STAGES - 1; k++) begin
      if (en[k]) begin
        vca_q[k] <= vca_q[k-1];
        vcb_q[k] <= vcb_q[k-1];
      end
    end
  end

  // ---- stage 0: beta current product, dead-time product
  logic signed [31:0] pib_full;
  logic signed [15:0] s0_ial;
  logic signed [30:0] s0_pib;
  logic [30:0]        s0_pdt;

  assign pib_full = 32'(i_beta) * 32'($signed({1'b0, SQRT3_HALF_Q15}));

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_ial <= i_alpha;
      s0_pib <= pib_full[30:0];
      s0_pdt <= 31'(cfg.dead_ratio) * 31'(vdc);
    end
  end

  // ---- stage 1: phase currents, dead-time voltage
  logic signed [31:0] half_a;
  logic signed [31:0] num_b;
  logic signed [31:0] num_c;
  logic signed [16:0] s1_ia;
  logic signed [16:0] s1_ib;
  logic signed [16:0] s1_ic;
  logic [15:0]        s1_vdt;

  assign half_a = 32'(s0_ial) <<< 14;
  assign num_b  = 32'(s0_pib) - half_a;
  assign num_c  = -half_a - 32'(s0_pib);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_ia  <= 17'(s0_ial);
      s1_ib  <= rnd15(num_b);
      s1_ic  <= rnd15(num_c);
      s1_vdt <= 16'((32'(s0_pdt) + 32'd32768) >> 16);
    end
  end

  // ---- stage 2: resistive products, signs, fixed part of magnitude
  logic signed [16:0] ph_i [3];
  logic signed [16:0] eps_pos;
  logic signed [16:0] eps_neg;
  logic [31:0]        s2_pr  [3];
  sgn_t               s2_sgn [3];
  logic [16:0]        s2_base;

  assign ph_i[0] = s1_ia;
  assign ph_i[1] = s1_ib;
  assign ph_i[2] = s1_ic;
  assign eps_pos = $signed({2'b00, cfg.current_deadband});
  assign eps_neg = -eps_pos;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int p = 0; p < 3; p++) begin
        s2_pr[p] <= 32'(cfg.on_resistance) * 32'(abs17(ph_i[p]));
        if (ph_i[p] > eps_pos) begin
          s2_sgn[p] <= SGN_POS;
        end else if (ph_i[p] < eps_neg) begin
          s2_sgn[p] <= SGN_NEG;
        end else begin
          s2_sgn[p] <= SGN_ZERO;
        end
      end
      s2_base <= 17'(s1_vdt) + 17'(cfg.diode_drop);
    end
  end

  // ---- stage 3: signed phase compensations
  logic [17:0]        mag [3];
  logic signed [17:0] s3_v [3];

  always_comb begin
    for (int p = 0; p < 3; p++) begin
      mag[p] = 18'(s2_base) + 18'((33'(s2_pr[p]) + 33'd32768) >> 16);
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int p = 0; p < 3; p++) begin
        case (s2_sgn[p])
          SGN_POS: s3_v[p] <= $signed(mag[p]);
          SGN_NEG: s3_v[p] <= -$signed(mag[p]);
          default: s3_v[p] <= '0;
        endcase
      end
    end
  end

  // ---- stage 4: Clarke numerators, beta gain product
  logic signed [19:0] na;
  logic signed [18:0] db;
  logic [17:0]        db_mag;
  logic [19:0]        s4_ya;
  logic               s4_na_neg;
  logic [33:0]        s4_pb;
  logic               s4_db_neg;

  assign na     = (20'(s3_v[0]) <<< 1) - 20'(s3_v[1]) - 20'(s3_v[2]);
  assign db     = 19'(s3_v[1]) - 19'(s3_v[2]);
  assign db_mag = db[18] ? 18'(-db) : 18'(db);

  always_ff @(posedge clk) begin
    if (en[4]) begin
      // round(|n|/3) = floor((|n|+1)/3)
      s4_ya     <= (na[19] ? 20'(-na) : 20'(na)) + 20'd1;
      s4_na_neg <= na[19];
      s4_pb     <= 34'(db_mag) * 34'(BETA_GAIN);
      s4_db_neg <= db[18];
    end
  end

  // ---- stage 5: beta dividend, round(m / (3*2^15)) = floor(((m+3*2^14)>>15)/3)
  logic [19:0] s5_ya;
  logic [19:0] s5_yb;
  logic        s5_na_neg;
  logic        s5_db_neg;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_ya     <= s4_ya;
      s5_yb     <= 20'((35'(s4_pb) + 35'd49152) >> 15);
      s5_na_neg <= s4_na_neg;
      s5_db_neg <= s4_db_neg;
    end
  end

  // ---- stage 6: divide by three through reciprocal
  logic [39:0] s6_qa;
  logic [39:0] s6_qb;
  logic        s6_na_neg;
  logic        s6_db_neg;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s6_qa     <= 40'(s5_ya) * 40'(DIV3_RECIP);
      s6_qb     <= 40'(s5_yb) * 40'(DIV3_RECIP);
      s6_na_neg <= s5_na_neg;
      s6_db_neg <= s5_db_neg;
    end
  end

  // ---- stage 7: add to command, saturate, output register
  logic signed [18:0] ca;
  logic signed [18:0] cb;
  logic signed [19:0] sum_a;
  logic signed [19:0] sum_b;
  logic               clip_a;
  logic               clip_b;
  logic signed [15:0] sat_a;
  logic signed [15:0] sat_b;

  assign ca    = sat_in($signed({1'b0, s6_qa[39:DIV3_SHIFT]}), s6_na_neg);
  assign cb    = sat_in($signed({1'b0, s6_qb[39:DIV3_SHIFT]}), s6_db_neg);
  assign sum_a = 20'(vca_q[NUM_STAGES-2]) + 20'(ca);
  assign sum_b = 20'(vcb_q[NUM_STAGES-2]) + 20'(cb);

  always_comb begin
    clip_a = 1'b1;
    clip_b = 1'b1;
    if (sum_a > 20'sd32767) begin
      sat_a = 16'sh7fff;
    end else if (sum_a < -20'sd32768) begin
      sat_a = -16'sh8000;
    end else begin
      sat_a  = sum_a[15:0];
      clip_a = 1'b0;
    end
    if (sum_b > 20'sd32767) begin
      sat_b = 16'sh7fff;
    end else if (sum_b < -20'sd32768) begin
      sat_b = -16'sh8000;
    end else begin
      sat_b  = sum_b[15:0];
      clip_b = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en[NUM_STAGES-1]) begin
      v_out_alpha <= sat_a;
      v_out_beta  <= sat_b;
      clipped     <= clip_a | clip_b;
    end
  end

endmodule

// ===== src/inverter_deadtime_compensation_top.sv =====
// Top level of the alpha-beta dead-time compensation block: request
// handshakes, configuration registers, pipeline control. Uses dtc_pkg,
// dtc_datapath and inverter_deadtime_compensation_top_assert.svh.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------------
//   in      | sink      | in_valid / in_stall  | v_cmd_alpha v_cmd_beta i_alpha
//           |           |                      | i_beta vdc
//   out     | source    | out_valid/out_stall  | v_out_alpha v_out_beta clipped
//   cfg     | sink      | cfg_valid/cfg_ready  | cfg_index cfg_data
//
// One request per cycle while in_stall is low. The datapath has eight
// register stages (the widest steps are the 18x16 beta gain product
// and the 20x20 reciprocal multiply for the divide by three).
// Synchronous reset clears the stage valid bits and the configuration
// registers (all zero). A stall on the output only holds the stages that
// are full up to it; empty stages behind keep filling, so in_stall rises
// only when all eight stages hold requests. cfg_ready is always high.
`timescale 1ns / 1ps
`include "inverter_deadtime_compensation_top_assert.svh"

module inverter_deadtime_compensation_top import dtc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  // input requests
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] v_cmd_alpha,
  input  logic signed [15:0] v_cmd_beta,
  input  logic signed [15:0] i_alpha,
  input  logic signed [15:0] i_beta,
  input  logic [14:0]        vdc,
  // results
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] v_out_alpha,
  output logic signed [15:0] v_out_beta,
  output logic               clipped,
  // configuration writes
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  dtc_cfg_t              cfg;
  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES-1:0] ready;
  logic                  out_taken;
  logic                  out_on_rail;

  // ---- configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_DEAD_RATIO:    cfg.dead_ratio       <= cfg_data;
        REG_DIODE_DROP:    cfg.diode_drop       <= cfg_data[14:0];
        REG_ON_RESISTANCE: cfg.on_resistance    <= cfg_data;
        REG_DEADBAND:      cfg.current_deadband <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // ---- pipeline control
  // A stage may load when it is empty or the stage after it moves on.
  always_comb begin
    ready[NUM_STAGES-1] = !vld[NUM_STAGES-1] || !out_stall;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      ready[k] = !vld[k] || ready[k+1];
    end
  end

  assign in_stall  = !ready[0];
  assign out_valid = vld[NUM_STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (ready[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (ready[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // ---- datapath
  dtc_datapath u_datapath (
    .clk         (clk),
    .en          (ready),
    .cfg         (cfg),
    .v_cmd_alpha (v_cmd_alpha),
    .v_cmd_beta  (v_cmd_beta),
    .i_alpha     (i_alpha),
    .i_beta      (i_beta),
    .vdc         (vdc),
    .v_out_alpha (v_out_alpha),
    .v_out_beta  (v_out_beta),
    .clipped     (clipped)
  );

  // ---- assertions
  assign out_taken   = out_valid && !out_stall;
  assign out_on_rail = v_out_alpha == 16'sh7fff || v_out_alpha == -16'sh8000 ||
                       v_out_beta == 16'sh7fff || v_out_beta == -16'sh8000;

  // input only backs up when every stage is occupied
  `DTC_ASSERT_NOW(a_stall_only_full, clk, rst, in_stall, &vld, "stall with a free stage")
  // a taken result with nothing behind it leaves the output empty
  `DTC_ASSERT_NEXT(a_no_repeat, clk, rst, out_taken && !vld[NUM_STAGES-2], !out_valid, "result repeated")
  // a clipped result sits on a rail
  `DTC_ASSERT_NOW(a_clip_rail, clk, rst, out_valid && clipped, out_on_rail, "clip flag off rail")

endmodule
